/* rtl/ucd_pkg.sv */
// Shared types, constants and lead byte helpers for the UTF-8 code point decoder.
// No dependencies; imported by utf8_codepoint_decoder.
`default_nettype none

package ucd_pkg;

    localparam logic [7:0]  ASCII_LIMIT    = 8'h80;
    localparam logic [7:0]  LEAD2_MASK     = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG      = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG      = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK     = 8'hF8;
    localparam logic [7:0]  LEAD4_TAG      = 8'hF0;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_TAG       = 8'h80;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // Sequence lengths announced by a lead byte.
    localparam logic [2:0] LEN_BAD  = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic [2:0]  byte_count;
        logic        last_of_run;
        logic        text_done;
    } out_item_t;

    function automatic logic [2:0] lead_len(input logic [7:0] lead);
        logic [2:0] len;
        priority if (lead < ASCII_LIMIT)
            len = LEN_ONE;
        else if ((lead & LEAD2_MASK) == LEAD2_TAG)
            len = LEN_TWO;
        else if ((lead & LEAD3_MASK) == LEAD3_TAG)
            len = LEN_THREE;
        else if ((lead & LEAD4_MASK) == LEAD4_TAG)
            len = LEN_FOUR;
        else
            len = LEN_BAD;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

endpackage

`default_nettype wire

/* rtl/utf8_codepoint_decoder.sv */
// UTF-8 code point decoder: byte stream in, code points out, one shared decode step.
// Depends on ucd_pkg for item types, lead byte constants and helpers.
// A byte is taken only while idle; the decode step then produces its results one per
// cycle while the output is not stalled. A byte yields n results (0..4), and the next
// byte is taken only once the results of the one before, if any, are out.
// Reset (rst_n low, asynchronous) empties the byte buffer and the output register;
// the held bytes are cleared as well, though they are never read unwritten.
`default_nettype none

module utf8_codepoint_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire ucd_pkg::in_item_t byte_item,
    output logic                   cp_valid,
    input  wire logic              cp_ready,
    output ucd_pkg::out_item_t     cp_item
);
    import ucd_pkg::*;

    typedef enum logic {
        IDLE,
        BUSY
    } state_t;

    state_t      state_reg;
    logic [7:0]  buf_reg [4];
    logic [2:0]  held_reg;
    logic        fin_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    // The decode step. It looks at the oldest held byte, works out the one
    // result it yields, and how many bytes that result consumes.
    logic [7:0]  lead;
    logic [2:0]  len;
    logic        incomplete;
    logic        conts_ok;
    logic [20:0] assembled;
    logic [20:0] cp_value;
    logic        rep_value;
    logic [2:0]  used;
    logic        produce;

    // What is left after this result, to tell whether another one follows.
    logic [2:0]  held_next;
    logic [7:0]  next_lead;
    logic [2:0]  next_len;
    logic        more;
    logic [7:0]  buf_next [4];
    logic        slot_free;
    logic        accept;

    assign lead       = buf_reg[0];
    assign len        = lead_len(lead);
    assign incomplete = held_reg < len;

    // Continuation bytes are only checked up to the announced length.
    assign conts_ok = (len < LEN_TWO   || is_cont(buf_reg[1]))
                   && (len < LEN_THREE || is_cont(buf_reg[2]))
                   && (len < LEN_FOUR  || is_cont(buf_reg[3]));

    always_comb
    begin
        assembled = '0;
        unique case (len)
            LEN_TWO:   assembled = {10'd0, lead[4:0], buf_reg[1][5:0]};
            LEN_THREE: assembled = {5'd0, lead[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            LEN_FOUR:  assembled = {lead[2:0], buf_reg[1][5:0], buf_reg[2][5:0],
                                    buf_reg[3][5:0]};
            default:   assembled = {13'd0, lead};
        endcase
    end

    always_comb
    begin
        cp_value  = REPLACEMENT_CP;
        rep_value = 1'b1;
        used      = LEN_ONE;
        priority if (len == LEN_ONE)
        begin
            cp_value  = {13'd0, lead};
            rep_value = 1'b0;
        end
        else if (len == LEN_BAD)
        begin
            // Invalid lead: replaced, one byte consumed.
        end
        else if (incomplete)
        begin
            // Text cut off inside a sequence: everything held goes into one replacement.
            used = held_reg;
        end
        else if (conts_ok)
        begin
            cp_value  = assembled;
            rep_value = 1'b0;
            used      = len;
        end
        else
        begin
            // Bad continuation: only the lead is consumed.
        end
    end

    // A result exists unless nothing is held, or the sequence still waits for bytes.
    assign produce = (held_reg != 3'd0) && (!incomplete || fin_reg);

    assign held_next = held_reg - used;
    assign next_lead = buf_reg[used[1:0]];
    assign next_len  = lead_len(next_lead);
    assign more      = (held_next != 3'd0) && ((held_next >= next_len) || fin_reg);

    // Drop the consumed bytes from the front of the buffer.
    always_comb
    begin
        logic [2:0] src;
        for (int k = 0; k < 4; k++)
        begin
            src = 3'(k) + used;
            if (src < 3'd4)
                buf_next[k] = buf_reg[src[1:0]];
            else
                buf_next[k] = buf_reg[k];
        end
    end

    assign slot_free  = !out_valid_reg || cp_ready;
    assign byte_ready = (state_reg == IDLE);
    assign accept     = byte_valid && byte_ready;
    assign cp_valid   = out_valid_reg;
    assign cp_item    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            held_reg      <= 3'd0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int k = 0; k < 4; k++)
                buf_reg[k] <= 8'h00;
        end
        else
        begin
            // A taken result is cleared unless the decode step refills the slot now.
            if (out_valid_reg && cp_ready && !(state_reg == BUSY && produce))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        // At most three bytes are held between items.
                        buf_reg[held_reg[1:0]] <= byte_item.in_byte;
                        held_reg               <= held_reg + 3'd1;
                        fin_reg                <= byte_item.final_byte;
                        state_reg              <= BUSY;
                    end
                end
                BUSY:
                begin
                    if (!produce)
                    begin
                        state_reg <= IDLE;
                        if (fin_reg)
                            held_reg <= 3'd0;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.code_point  <= cp_value;
                        out_reg.replaced    <= rep_value;
                        out_reg.byte_count  <= used;
                        out_reg.last_of_run <= !more;
                        out_reg.text_done   <= !more && fin_reg;
                        for (int k = 0; k < 4; k++)
                            buf_reg[k] <= buf_next[k];
                        if (!more)
                        begin
                            state_reg <= IDLE;
                            held_reg  <= fin_reg ? 3'd0 : held_next;
                        end
                        else
                        begin
                            held_reg <= held_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Between items no more than three bytes wait for the rest of a sequence.
    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == IDLE |-> held_reg <= 3'd3)
        else $error("more than three bytes held while idle");

    // The end of a text is always the last result of its byte.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_item.text_done |-> cp_item.last_of_run)
        else $error("text_done without last_of_run");

    // A result never consumes more bytes than a sequence can hold.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> (cp_item.byte_count >= 3'd1 && cp_item.byte_count <= 3'd4))
        else $error("byte_count out of range");

    // After the final byte of a text has been worked off, nothing stays held.
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BUSY && fin_reg && !produce |=> held_reg == 3'd0)
        else $error("bytes left over after end of text");
`endif

endmodule

`default_nettype wire

/* test/utf8_codepoint_decoder_tb.sv */
// Self-checking testbench for utf8_codepoint_decoder: random UTF-8 texts in, code points checked.
// Depends on ucd_pkg for the byte and code point item types and the lead byte constants.
`timescale 1ns / 1ps

module utf8_codepoint_decoder_tb;

    import ucd_pkg::*;

    // Scoreboard: an independent byte-level decoder predicts the code points that
    // each accepted byte releases, and the results from the block are checked in order.
    class cp_scoreboard;

        logic [7:0]  held_bytes [4];
        int unsigned held_cnt;
        out_item_t   pending_cps [$];
        int unsigned fail_count;

        function new();
            foreach (held_bytes[k])
                held_bytes[k] = 8'h00;
            held_cnt   = 0;
            fail_count = 0;
        endfunction

        // Length of the sequence that a lead byte announces; LEN_BAD for an invalid lead.
        function logic [2:0] seq_len(input logic [7:0] lead);
            casez (lead)
                8'b0???????: return LEN_ONE;
                8'b110?????: return LEN_TWO;
                8'b1110????: return LEN_THREE;
                8'b11110???: return LEN_FOUR;
                default:     return LEN_BAD;
            endcase
        endfunction

        function void log_fail(input string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        // Called for every accepted byte. Appends the code points this byte releases.
        function void note_byte(input in_item_t item);
            out_item_t   step_cps [$];
            out_item_t   res;
            logic [7:0]  lead;
            logic [7:0]  c;
            logic [2:0]  len;
            logic [20:0] cp;
            int unsigned used;
            int unsigned k;
            bit          rep;
            bit          ok;
            held_bytes[held_cnt] = item.in_byte;
            held_cnt++;
            while (held_cnt > 0 && step_cps.size() < 4)
            begin
                lead = held_bytes[0];
                len  = seq_len(lead);
                rep  = 1'b0;
                if (len == LEN_ONE)
                begin
                    cp   = 21'(lead);
                    used = 1;
                end
                else if (len == LEN_BAD)
                begin
                    cp   = REPLACEMENT_CP;
                    used = 1;
                    rep  = 1'b1;
                end
                else if (held_cnt < len)
                begin
                    // Incomplete sequence: wait for more, unless the text ends here,
                    // in which case every held byte goes into one replacement.
                    if (!item.final_byte)
                        break;
                    cp   = REPLACEMENT_CP;
                    used = held_cnt;
                    rep  = 1'b1;
                end
                else
                begin
                    case (len)
                        LEN_TWO:   cp = 21'(lead & ~LEAD2_MASK);
                        LEN_THREE: cp = 21'(lead & ~LEAD3_MASK);
                        default:   cp = 21'(lead & ~LEAD4_MASK);
                    endcase
                    ok = 1'b1;
                    for (k = 1; k < len && ok; k++)
                    begin
                        c = held_bytes[k];
                        if ((c & CONT_MASK) != CONT_TAG)
                            ok = 1'b0;
                        else
                            cp = {cp[14:0], c[5:0]};
                    end
                    if (ok)
                    begin
                        used = len;
                    end
                    else
                    begin
                        // Only the lead is consumed; decoding restarts after it.
                        cp   = REPLACEMENT_CP;
                        used = 1;
                        rep  = 1'b1;
                    end
                end
                res.code_point  = cp;
                res.replaced    = rep;
                res.byte_count  = used[2:0];
                res.last_of_run = 1'b0;
                res.text_done   = 1'b0;
                step_cps.insert(step_cps.size(), res);
                for (k = 0; k + used < held_cnt; k++)
                    held_bytes[k] = held_bytes[k + used];
                held_cnt -= used;
            end
            if (item.final_byte)
                held_cnt = 0;
            foreach (step_cps[k])
            begin
                res = step_cps[k];
                if (k == step_cps.size() - 1)
                begin
                    res.last_of_run = 1'b1;
                    res.text_done   = item.final_byte;
                end
                pending_cps.insert(pending_cps.size(), res);
            end
        endfunction

        // Called for every accepted code point from the block.
        function void check_cp(input out_item_t got);
            out_item_t want;
            if (pending_cps.size() == 0)
            begin
                log_fail($sformatf("unexpected code point %h rep=%0b cnt=%0d last=%0b done=%0b",
                                   got.code_point, got.replaced, got.byte_count,
                                   got.last_of_run, got.text_done));
                return;
            end
            want = pending_cps.pop_front();
            if (got.code_point !== want.code_point || got.replaced !== want.replaced ||
                got.byte_count !== want.byte_count || got.last_of_run !== want.last_of_run ||
                got.text_done !== want.text_done)
                log_fail($sformatf({"mismatch: expected cp=%h rep=%0b cnt=%0d last=%0b done=%0b,",
                                    " got cp=%h rep=%0b cnt=%0d last=%0b done=%0b"},
                                   want.code_point, want.replaced, want.byte_count,
                                   want.last_of_run, want.text_done,
                                   got.code_point, got.replaced, got.byte_count,
                                   got.last_of_run, got.text_done));
        endfunction

        function void check_drained();
            if (pending_cps.size() != 0)
                log_fail($sformatf("%0d expected code points never arrived",
                                   pending_cps.size()));
        endfunction

    endclass

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic      clk;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    in_item_t  byte_item  = '0;
    logic      cp_valid;
    logic      cp_ready   = 1'b0;
    out_item_t cp_item;

    // Knobs shared by the stimulus, the receiver and the main sequence.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned bytes_sent   = 0;
    bit          hold_req     = 1'b0;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 105;
    localparam int unsigned DRAIN_CYCLES = 12;

    cp_scoreboard sb;

    utf8_codepoint_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_item (byte_item),
        .cp_valid  (cp_valid),
        .cp_ready  (cp_ready),
        .cp_item   (cp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both handshakes are observed with the values that were present at the edge.
    // The block's results are registered, so noting the byte first is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.note_byte(byte_item);
            if (cp_valid && cp_ready)
                sb.check_cp(cp_item);
        end
    end

    // Receiver. It stalls at random at the current rate, and on request it holds
    // off for a long stretch so that the output stalls and, with it, the input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                cp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            cp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one byte. Idle cycles come first, at the current rate; once the item is
    // offered, valid and payload hold until the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_item_t item;
        item.in_byte    = b;
        item.final_byte = fin;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Append a lead of the given length and n_cont continuation bytes that carry
    // the top bits of the payload. With n_cont < len - 1 the sequence is cut short.
    function automatic void push_seq(ref logic [7:0] text[$], input int len,
                                     input logic [20:0] bits, input int n_cont);
        logic [20:0] part;
        int          i;
        part = bits >> (6 * (len - 1));
        case (len)
            2:       text.insert(text.size(), LEAD2_TAG | (part[7:0] & ~LEAD2_MASK));
            3:       text.insert(text.size(), LEAD3_TAG | (part[7:0] & ~LEAD3_MASK));
            default: text.insert(text.size(), LEAD4_TAG | (part[7:0] & ~LEAD4_MASK));
        endcase
        for (i = 1; i <= n_cont; i++)
        begin
            part = bits >> (6 * (len - 1 - i));
            text.insert(text.size(), CONT_TAG | (part[7:0] & ~CONT_MASK));
        end
    endfunction

    // Short directed text: ASCII extremes, a typical two-byte and four-byte form, the
    // largest four-byte form, a well-formed U+FFFD (not a replacement), invalid leads,
    // a bad continuation, one byte that releases four results, and a text that ends
    // inside a sequence whose held tail is not even a continuation byte.
    task automatic send_directed();
        logic [7:0] opening [25] = '{
            8'h00, 8'h7F,
            8'hC2, 8'hA9,
            8'hEF, 8'hBF, 8'hBD,
            8'hF0, 8'h9F, 8'h98, 8'h80,
            8'hF7, 8'hBF, 8'hBF, 8'hBF,
            8'h80,
            8'hFF,
            8'hC3, 8'h41,
            8'hF0, 8'h80, 8'h80, 8'h41,
            8'hE0, 8'h41
        };
        foreach (opening[k])
            send_byte(opening[k], k == 24);
    endtask

    // One random text. Most characters are well-formed encodings with random
    // payloads; the rest are raw bytes, sequences cut short by the next character,
    // and sequences broken by a byte that is not a continuation. Some texts end
    // inside a sequence, and a few run on into the next text without a final byte.
    task automatic send_text();
        logic [7:0]  text [$];
        logic [20:0] bits;
        logic [7:0]  junk;
        int          n_chars;
        int          pick;
        int          len;
        bit          closes;
        n_chars = $urandom_range(1, 8);
        repeat (n_chars)
        begin
            pick = $urandom_range(99);
            len  = $urandom_range(2, 4);
            bits = 21'($urandom);
            if (pick < 30)
            begin
                text.insert(text.size(), {1'b0, bits[6:0]});
            end
            else if (pick < 80)
            begin
                len = 2 + (pick - 30) / 17;
                push_seq(text, len, bits, len - 1);
            end
            else if (pick < 88)
            begin
                text.insert(text.size(), 8'($urandom_range(255)));
            end
            else if (pick < 94)
            begin
                push_seq(text, len, bits, $urandom_range(0, len - 2));
            end
            else
            begin
                push_seq(text, len, bits, $urandom_range(0, len - 2));
                junk = 8'($urandom_range(255));
                if ((junk & CONT_MASK) == CONT_TAG)
                    junk ^= 8'h40;
                text.insert(text.size(), junk);
            end
        end
        if ($urandom_range(99) < 15)
        begin
            len  = $urandom_range(2, 4);
            bits = 21'($urandom);
            push_seq(text, len, bits, $urandom_range(0, len - 2));
        end
        closes = ($urandom_range(9) != 0);
        foreach (text[k])
            send_byte(text[k], closes && (k == text.size() - 1));
    endtask

    // Main sequence: reset, the directed text, then four phases of random
    // texts. The long receiver hold-off is requested at the start of the first one.
    initial
    begin
        int unsigned phase;
        int unsigned quota;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_req     = 1'b1;
                end
                1:
                begin
                    tx_idle_pct  = 74;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 74;
                end
                default:
                begin
                    tx_idle_pct  = 26;
                    rx_stall_pct = 26;
                end
            endcase
            quota = bytes_sent + PHASE_BYTES;
            while (bytes_sent < quota)
                send_text();
        end
        byte_valid <= 1'b0;

        // Let the monitor note the last byte, wait for every expected code point,
        // then wait out DRAIN_CYCLES so that any stray result from the block shows.
        @(posedge clk);
        while (sb.pending_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();

        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ucd_pkg.sv
rtl/utf8_codepoint_decoder.sv
test/utf8_codepoint_decoder_tb.sv
